/* hw/rtl/lbs_pkg.sv */
// Shared types and constants of the letterbox nearest-neighbor scaler.
// Used by every module of the block but lbs_ram; depends on nothing.
package lbs_pkg;

  // Source frame geometry.
  localparam int unsigned SRC_WIDTH   = 320;
  localparam int unsigned SRC_HEIGHT  = 180;
  localparam int unsigned FRAME_WORDS = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(FRAME_WORDS);
  localparam int unsigned X_W         = $clog2(SRC_WIDTH);
  localparam int unsigned Y_W         = $clog2(SRC_HEIGHT);
  localparam int unsigned Q_W         = (X_W > Y_W) ? X_W : Y_W;

  // Field widths.
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned LX_W    = 9;
  localparam int unsigned LY_W    = 8;
  localparam int unsigned COL_W   = 32;

  // Remainder width of the quotient pipeline: offset times source size.
  localparam int unsigned DIV_W = COORD_W + Q_W;

  // Viewport size by nine: n * DIV9_MUL >> DIV9_SHIFT is exact for n below 2^17.
  localparam int unsigned GEO_N_W    = DIM_W + 4;
  localparam int unsigned GEO_P_W    = 2 * GEO_N_W;
  localparam logic [GEO_N_W-1:0] DIV9_MUL = GEO_N_W'(116509);
  localparam int unsigned DIV9_SHIFT = 20;

  localparam logic [COL_W-1:0] BAR_COLOR = 32'hFF05070A;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0] OUT_WIDTH_RST  = 13'd1920;
  localparam logic [DIM_W-1:0] OUT_HEIGHT_RST = 13'd1080;

  // Queue between front and back.
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_PTR_W;

  typedef struct packed {
    logic               req_type;
    logic [LX_W-1:0]    load_x;
    logic [LY_W-1:0]    load_y;
    logic [COL_W-1:0]   load_color;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] pixel_color;
    logic             in_viewport;
  } out_item_t;

  // One queued operation: a frame write or a frame read for a request.
  typedef struct packed {
    logic              is_load;
    logic              we;
    logic              in_vp;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  color;
  } q_entry_t;

endpackage

/* hw/rtl/lbs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the source frame of the scaler.
module lbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lbs_fifo.sv */
// Short queue of frame operations between the front and the back part.
// Depends on lbs_pkg for the entry type and depth.
module lbs_fifo import lbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output q_entry_t head_o
);

  q_entry_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

/* hw/rtl/lbs_front.sv */
// Front part: configuration registers, viewport geometry, item classification,
// quotient pipeline for the source coordinates and frame address generation.
// Depends on lbs_pkg.
module lbs_front import lbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 push_o,
  output q_entry_t             push_entry_o,
  input  logic                 full_i
);

  typedef struct packed {
    logic               req;
    logic               load_ok;
    logic               in_vp;
    logic [LX_W-1:0]    lx;
    logic [LY_W-1:0]    ly;
    logic [COL_W-1:0]   color;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [DIM_W-1:0]   vw;
    logic [DIM_W-1:0]   vh;
  } cls_t;

  typedef struct packed {
    logic             req;
    logic             load_ok;
    logic             in_vp;
    logic [LX_W-1:0]  lx;
    logic [LY_W-1:0]  ly;
    logic [COL_W-1:0] color;
    logic [DIV_W-1:0] rx;
    logic [DIV_W-1:0] ry;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic [DIM_W-1:0] vw;
    logic [DIM_W-1:0] vh;
  } div_t;

  // One restoring step: resolves quotient bit b of both coordinates.
  function automatic div_t div_step(input div_t s, input int unsigned b);
    div_t             r;
    logic [DIV_W-1:0] dvx;
    logic [DIV_W-1:0] dvy;
    r   = s;
    dvx = DIV_W'(s.vw) << b;
    dvy = DIV_W'(s.vh) << b;
    if (s.rx >= dvx) begin
      r.rx    = s.rx - dvx;
      r.qx[b] = 1'b1;
    end
    if (s.ry >= dvy) begin
      r.ry    = s.ry - dvy;
      r.qy[b] = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [DIM_W-1:0] w_q, w_d, h_q, h_d;

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUT_WIDTH:  w_d = cfg_wdata_i;
        CFG_OUT_HEIGHT: h_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= OUT_WIDTH_RST;
      h_q <= OUT_HEIGHT_RST;
    end else begin
      w_q <= w_d;
      h_q <= h_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry pipeline, run every cycle. The user must change registers only
  // with no item in flight, unenforced; stage k settles before items reach it.
  logic                 pil1_q, pil1_d, pil2_q;
  logic [GEO_N_W-1:0]   n1_q, n1_d, w9, h16;
  logic [DIM_W-1:0]     w1_q, h1_q, w2_q, h2_q;
  logic [GEO_P_W-1:0]   prod;
  logic [DIM_W-1:0]     vq2_q, vq2_d;
  logic [DIM_W-1:0]     diff_w, diff_h;
  logic [DIM_W-1:0]     vw3_q, vw3_d, vh3_q, vh3_d;
  logic [COORD_W-1:0]   vx3_q, vx3_d, vy3_q, vy3_d;

  always_comb begin
    w9     = {1'b0, w_q, 3'b000} + GEO_N_W'(w_q);
    h16    = {h_q, 4'b0000};
    pil1_d = (w9 > h16);
    n1_d   = pil1_d ? h16 : w9;

    prod  = GEO_P_W'(n1_q) * GEO_P_W'(DIV9_MUL);
    vq2_d = pil1_q ? prod[DIV9_SHIFT +: DIM_W] : n1_q[GEO_N_W-1:4];

    diff_w = w2_q - vq2_q;
    diff_h = h2_q - vq2_q;
    if (pil2_q) begin
      vw3_d = vq2_q;
      vh3_d = h2_q;
      vx3_d = diff_w[DIM_W-1:1];
      vy3_d = '0;
    end else begin
      vw3_d = w2_q;
      vh3_d = vq2_q;
      vx3_d = '0;
      vy3_d = diff_h[DIM_W-1:1];
    end
    // Sizes are raised to one after the offsets are taken.
    if (vw3_d == '0) begin
      vw3_d = DIM_W'(1);
    end
    if (vh3_d == '0) begin
      vh3_d = DIM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    pil1_q <= pil1_d;
    n1_q   <= n1_d;
    w1_q   <= w_q;
    h1_q   <= h_q;
    pil2_q <= pil1_q;
    vq2_q  <= vq2_d;
    w2_q   <= w1_q;
    h2_q   <= h1_q;
    vw3_q  <= vw3_d;
    vh3_q  <= vh3_d;
    vx3_q  <= vx3_d;
    vy3_q  <= vy3_d;
  end

  // ---------------------------------------------------------------------------
  // Item pipeline; all stages move together unless va_q meets a full queue.
  logic     en;
  logic     v1_q, v2_q, v3_q, vc_q, va_q;
  logic     dv_q [Q_W+1];
  in_item_t p1_q, p2_q, p3_q;
  cls_t     c_q, c_d;
  div_t     d_q [Q_W+1];
  div_t     d_d [Q_W+1];
  q_entry_t a_q, a_d;

  assign en         = !(va_q && full_i);
  assign in_ready_o = en;

  always_comb begin
    c_d.req     = p3_q.req_type;
    c_d.load_ok = (32'(p3_q.load_x) < SRC_WIDTH) && (32'(p3_q.load_y) < SRC_HEIGHT);
    c_d.lx      = p3_q.load_x;
    c_d.ly      = p3_q.load_y;
    c_d.color   = p3_q.load_color;
    c_d.dx      = p3_q.out_x - vx3_q;
    c_d.dy      = p3_q.out_y - vy3_q;
    c_d.in_vp   = (p3_q.out_x >= vx3_q) && (DIM_W'(c_d.dx) < vw3_q) &&
                  (p3_q.out_y >= vy3_q) && (DIM_W'(c_d.dy) < vh3_q);
    c_d.vw      = vw3_q;
    c_d.vh      = vh3_q;

    d_d[0].req     = c_q.req;
    d_d[0].load_ok = c_q.load_ok;
    d_d[0].in_vp   = c_q.in_vp;
    d_d[0].lx      = c_q.lx;
    d_d[0].ly      = c_q.ly;
    d_d[0].color   = c_q.color;
    d_d[0].rx      = DIV_W'(c_q.dx) * DIV_W'(SRC_WIDTH);
    d_d[0].ry      = DIV_W'(c_q.dy) * DIV_W'(SRC_HEIGHT);
    d_d[0].qx      = '0;
    d_d[0].qy      = '0;
    d_d[0].vw      = c_q.vw;
    d_d[0].vh      = c_q.vh;

    for (int unsigned k = 0; k < Q_W; k++) begin
      d_d[k+1] = div_step(d_q[k], Q_W - 1 - k);
    end

    a_d.is_load = !d_q[Q_W].req;
    a_d.we      = d_q[Q_W].load_ok;
    a_d.in_vp   = d_q[Q_W].in_vp;
    a_d.color   = d_q[Q_W].color;
    if (d_q[Q_W].req) begin
      a_d.addr = ADDR_W'(d_q[Q_W].qy[Y_W-1:0]) * ADDR_W'(SRC_WIDTH) +
                 ADDR_W'(d_q[Q_W].qx[X_W-1:0]);
    end else begin
      a_d.addr = ADDR_W'(d_q[Q_W].ly) * ADDR_W'(SRC_WIDTH) + ADDR_W'(d_q[Q_W].lx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vc_q <= 1'b0;
      va_q <= 1'b0;
      for (int unsigned k = 0; k <= Q_W; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      vc_q     <= v3_q;
      dv_q[0]  <= vc_q;
      for (int unsigned k = 0; k < Q_W; k++) begin
        dv_q[k+1] <= dv_q[k];
      end
      va_q     <= dv_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= in_item_i;
      p2_q <= p1_q;
      p3_q <= p2_q;
      c_q  <= c_d;
      for (int unsigned k = 0; k <= Q_W; k++) begin
        d_q[k] <= d_d[k];
      end
      a_q  <= a_d;
    end
  end

  assign push_o       = va_q && !full_i;
  assign push_entry_o = a_q;

endmodule

/* hw/rtl/lbs_back.sv */
// Back part: carries out queued frame writes and reads in order and holds
// the result item in an output register. Depends on lbs_pkg and lbs_ram.
module lbs_back import lbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  q_entry_t  head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic             out_adv, rd_ready;
  logic             ram_we, ram_re;
  logic [COL_W-1:0] rdata;
  logic             rd_valid_q, rd_valid_d;
  logic             rd_inside_q, rd_inside_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  assign out_adv  = !out_valid_q || out_ready_i;
  assign rd_ready = !rd_valid_q || out_adv;
  // Writes never wait on the read stage; reads wait until it can move on.
  assign pop_o    = head_valid_i && (head_i.is_load || rd_ready);
  assign ram_we   = pop_o && head_i.is_load && head_i.we;
  assign ram_re   = pop_o && !head_i.is_load;

  lbs_ram #(
    .WIDTH (COL_W),
    .DEPTH (FRAME_WORDS)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.addr),
    .wdata_i (head_i.color),
    .re_i    (ram_re),
    .raddr_i (head_i.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    rd_valid_d  = rd_ready ? ram_re : rd_valid_q;
    rd_inside_d = ram_re ? head_i.in_vp : rd_inside_q;
    out_valid_d = out_adv ? rd_valid_q : out_valid_q;
    out_item_d  = out_item_q;
    if (out_adv && rd_valid_q) begin
      out_item_d.pixel_color = rd_inside_q ? rdata : BAR_COLOR;
      out_item_d.in_viewport = rd_inside_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_inside_q <= rd_inside_d;
    out_item_q  <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* hw/rtl/letterbox_nearest_scaler.sv */
// Top level of the letterbox nearest-neighbor scaler.
// Depends on lbs_pkg, lbs_front, lbs_fifo and lbs_back.
//
// Usage:
//   Input items arrive on in_valid_i/in_ready_o with in_item_i. A load item
//   (req_type 0) writes one pixel of the 320x180 source frame, or nothing if
//   it lies outside; a request item (req_type 1) asks for one output pixel
//   and yields exactly one result item on out_valid_o/out_ready_i with
//   out_item_o. Loads give no result. Output width and height are set
//   through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must set them only
//   while no item is in flight; the block does not enforce this.
//   Throughput is one item per cycle while nothing stalls. A request passes
//   through the geometry alignment registers, classification, the numerator
//   stage, one stage per quotient bit (nine at a 320-wide source), address
//   generation, the queue, the frame RAM read and the output register.
//   Reset restores 1920x1080 and empties all pipelines; the frame contents
//   are not cleared, so a pixel must be loaded before it is requested.
//   When the receiver stalls, the output register holds its item, the four
//   entry queue fills, and then in_ready_o drops until space frees up.
module letterbox_nearest_scaler import lbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  logic     push, full, pop, head_valid;
  q_entry_t push_entry, head;

  lbs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  lbs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule
